FILE: hw/rtl/ssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants of the stop sequence matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int SSM_MAX_STOP_LEN = 16;   // default window depth
    localparam int SSM_PATTERN_BYTES = 16;  // bytes held by the pattern registers
    localparam int SSM_LEN_W = 5;
    localparam int SSM_POS_W = 32;
    localparam int SSM_HELD_W = 4;
    localparam int SSM_CFG_DATA_W = 64;
    localparam int SSM_CFG_INDEX_W = 3;

    typedef enum logic [SSM_CFG_INDEX_W-1:0] {
        REG_PATTERN_A_LOW    = 3'd0,
        REG_PATTERN_A_HIGH   = 3'd1,
        REG_PATTERN_A_LENGTH = 3'd2,
        REG_PATTERN_B_LOW    = 3'd3,
        REG_PATTERN_B_HIGH   = 3'd4,
        REG_PATTERN_B_LENGTH = 3'd5
    } ssm_reg_t;

    typedef struct packed {
        logic [8*SSM_PATTERN_BYTES-1:0] bytes;   // byte 0 in bits 7:0
        logic [SSM_LEN_W-1:0]           length;
    } ssm_pattern_t;

    typedef struct packed {
        logic                  match_found;
        logic                  match_pattern;
        logic [SSM_LEN_W-1:0]  match_len;
        logic [SSM_HELD_W-1:0] held_length;
    } ssm_result_t;

endpackage

FILE: hw/rtl/ssm_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm channels
// Valid/ready channels of the stop sequence matcher: text in, result out,
// register write.
// ----------------------------------------------------------------------------
interface ssm_text_if
    import ssm_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       restart;

    modport source (output valid, output text_byte, output restart, input ready);
    modport sink   (input valid, input text_byte, input restart, output ready);
endinterface

interface ssm_result_if
    import ssm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  match_found;
    logic                  match_pattern;
    logic [SSM_POS_W-1:0]  match_start;
    logic [SSM_HELD_W-1:0] held_length;

    modport source (output valid, output match_found, output match_pattern,
                    output match_start, output held_length, input ready);
    modport sink   (input valid, input match_found, input match_pattern,
                    input match_start, input held_length, output ready);
endinterface

interface ssm_cfg_if
    import ssm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [SSM_CFG_INDEX_W-1:0] index;
    logic [SSM_CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/stop_sequence_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_sequence_matcher_unit
// Scans generated text for two configurable stop patterns, one byte per
// request, and reports matches and the length of text to hold back.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                             | handshake
//   --------+-----+-----------------------------------------------------+------------
//   text    | in  | text_byte[7:0], restart                             | valid/ready
//   result  | out | match_found, match_pattern, match_start[31:0],      | valid/ready
//           |     | held_length[3:0]                                    |
//   cfg     | in  | index[2:0], data[63:0]                              | valid/ready
//
// One text request per cycle while results are taken; each result passes
// through the cell chain and then the output register.
// The window is a chain of MAX_STOP_LEN cells shifted on every request; all
// compares of a window run in parallel behind it.
// Reset clears the window valid flags, the position and every pattern
// register; no clearing pass is needed. cfg is always ready.
// A stalled result holds the output register; the chain then holds one more
// request and stops taking text until the output register frees.
// ----------------------------------------------------------------------------
module stop_sequence_matcher_unit
    import ssm_pkg::*;
#(
    parameter int MAX_STOP_LEN = SSM_MAX_STOP_LEN
) (
    input  logic                clk,
    input  logic                rst_n,
    ssm_text_if.sink            text,
    ssm_result_if.source        result,
    ssm_cfg_if.sink             cfg
);

    // ------------------------------------------------------------------
    // Pattern registers
    // ------------------------------------------------------------------
    ssm_pattern_t pattern_a_reg;
    ssm_pattern_t pattern_b_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_a_reg <= '0;
            pattern_b_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (ssm_reg_t'(cfg.index))
                REG_PATTERN_A_LOW:    pattern_a_reg.bytes[63:0]   <= cfg.data;
                REG_PATTERN_A_HIGH:   pattern_a_reg.bytes[127:64] <= cfg.data;
                REG_PATTERN_A_LENGTH: pattern_a_reg.length <= cfg.data[SSM_LEN_W-1:0];
                REG_PATTERN_B_LOW:    pattern_b_reg.bytes[63:0]   <= cfg.data;
                REG_PATTERN_B_HIGH:   pattern_b_reg.bytes[127:64] <= cfg.data;
                REG_PATTERN_B_LENGTH: pattern_b_reg.length <= cfg.data[SSM_LEN_W-1:0];
                default: ;  // write beyond the register list: drop it
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: chain stage (pend) and output register
    // ------------------------------------------------------------------
    logic                 pend_reg;
    logic                 out_valid_reg;
    logic                 out_free;
    logic                 accept;
    logic [SSM_POS_W-1:0] next_pos_reg;
    logic [SSM_POS_W-1:0] item_pos_reg;
    logic [SSM_POS_W-1:0] pos_base;

    assign out_free   = !out_valid_reg || result.ready;
    assign text.ready = !pend_reg || out_free;
    assign accept     = text.valid && text.ready;

    // Restart counts this byte as position zero.
    assign pos_base = text.restart ? '0 : next_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            next_pos_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg     <= 1'b1;
                next_pos_reg <= pos_base + SSM_POS_W'(1);
            end
            else if (out_free)
            begin
                pend_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_pos_reg <= pos_base;
        end
    end

    // ------------------------------------------------------------------
    // Window: chain of cells, newest byte in cell zero
    // ------------------------------------------------------------------
    logic [7:0]              chain_byte  [MAX_STOP_LEN];
    logic                    chain_valid [MAX_STOP_LEN];
    logic [MAX_STOP_LEN-1:0] eq_a        [MAX_STOP_LEN];
    logic [MAX_STOP_LEN-1:0] eq_b        [MAX_STOP_LEN];
    logic [MAX_STOP_LEN-1:0] win_valid;

    for (genvar g = 0; g < MAX_STOP_LEN; g++)
    begin : g_cell
        logic [7:0] byte_in;
        logic       valid_in;

        if (g == 0)
        begin : g_head
            assign byte_in  = text.text_byte;
            assign valid_in = 1'b1;
        end
        else
        begin : g_body
            // restart empties every older cell
            assign byte_in  = chain_byte[g-1];
            assign valid_in = chain_valid[g-1] && !text.restart;
        end

        ssm_cell #(
            .MAX_STOP_LEN (MAX_STOP_LEN)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (accept),
            .byte_in   (byte_in),
            .valid_in  (valid_in),
            .pattern_a (pattern_a_reg),
            .pattern_b (pattern_b_reg),
            .byte_out  (chain_byte[g]),
            .valid_out (chain_valid[g]),
            .eq_a      (eq_a[g]),
            .eq_b      (eq_b[g])
        );

        assign win_valid[g] = chain_valid[g];
    end

    // ------------------------------------------------------------------
    // Resolve and output register
    // ------------------------------------------------------------------
    ssm_result_t          resolved;
    logic                 found_reg;
    logic                 pattern_reg;
    logic [SSM_POS_W-1:0] start_reg;
    logic [SSM_HELD_W-1:0] held_reg;

    ssm_resolve #(
        .MAX_STOP_LEN (MAX_STOP_LEN)
    ) u_resolve (
        .eq_a     (eq_a),
        .eq_b     (eq_b),
        .length_a (pattern_a_reg.length),
        .length_b (pattern_b_reg.length),
        .result   (resolved)
    );

    // Load the pending request; zero pattern and start when nothing matched.
    always_ff @(posedge clk)
    begin
        if (out_free && pend_reg)
        begin
            found_reg   <= resolved.match_found;
            pattern_reg <= resolved.match_found && resolved.match_pattern;
            start_reg   <= resolved.match_found
                         ? (item_pos_reg - SSM_POS_W'(resolved.match_len) + SSM_POS_W'(1))
                         : '0;
            held_reg    <= resolved.held_length;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.match_found   = found_reg;
    assign result.match_pattern = pattern_reg;
    assign result.match_start   = start_reg;
    assign result.held_length   = held_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic [MAX_STOP_LEN-1:0] win_valid_shift;
    assign win_valid_shift = {win_valid[MAX_STOP_LEN-2:0], 1'b1};

    // Window fill is always a run from the newest cell.
    a_window_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid & ~win_valid_shift) == '0)
        else $error("window valid flags not contiguous");

    // Restart leaves only the new byte in the window.
    a_restart_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text.restart) |=> (win_valid == MAX_STOP_LEN'(1)))
        else $error("restart did not empty the window");

    // A blocked pending request keeps its position.
    a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !out_free) |=> (pend_reg && $stable(item_pos_reg)))
        else $error("pending request lost under stall");

    // No match reports zero pattern and start.
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.match_found) |->
            (result.match_start == '0 && !result.match_pattern))
        else $error("non-zero start without a match");

    // Held run is always shorter than the window.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (32'(result.held_length) < MAX_STOP_LEN))
        else $error("held length out of range");

endmodule

FILE: hw/rtl/ssm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_cell
// One window cell: holds a text byte and its valid flag, passes them on to
// the next cell on every shift and compares the byte with every pattern byte.
// ----------------------------------------------------------------------------
module ssm_cell
    import ssm_pkg::*;
#(
    parameter int MAX_STOP_LEN = SSM_MAX_STOP_LEN
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift,
    input  logic [7:0]              byte_in,
    input  logic                    valid_in,
    input  ssm_pattern_t            pattern_a,
    input  ssm_pattern_t            pattern_b,
    output logic [7:0]              byte_out,
    output logic                    valid_out,
    output logic [MAX_STOP_LEN-1:0] eq_a,
    output logic [MAX_STOP_LEN-1:0] eq_b
);

    logic [7:0] byte_reg;
    logic       valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    // Compare against every pattern byte; an empty cell matches nothing.
    always_comb
    begin
        for (int j = 0; j < MAX_STOP_LEN; j++)
        begin
            eq_a[j] = valid_reg && (byte_reg == pattern_a.bytes[8*j +: 8]);
            eq_b[j] = valid_reg && (byte_reg == pattern_b.bytes[8*j +: 8]);
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

FILE: hw/rtl/ssm_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_resolve
// Combines the cell compares along the diagonals into tail matches, picks
// the winning stop pattern and finds the longest held-back prefix.
// ----------------------------------------------------------------------------
module ssm_resolve
    import ssm_pkg::*;
#(
    parameter int MAX_STOP_LEN = SSM_MAX_STOP_LEN
) (
    input  logic [MAX_STOP_LEN-1:0] eq_a [MAX_STOP_LEN],
    input  logic [MAX_STOP_LEN-1:0] eq_b [MAX_STOP_LEN],
    input  logic [SSM_LEN_W-1:0]    length_a,
    input  logic [SSM_LEN_W-1:0]    length_b,
    output ssm_result_t             result
);

    localparam logic [SSM_LEN_W-1:0] MAX_LEN = SSM_LEN_W'(MAX_STOP_LEN);

    logic [MAX_STOP_LEN:1]   tail_a;
    logic [MAX_STOP_LEN:1]   tail_b;
    logic [SSM_LEN_W-1:0]    eff_a;
    logic [SSM_LEN_W-1:0]    eff_b;
    logic                    hit_a;
    logic                    hit_b;
    logic [SSM_HELD_W-1:0]   held_a;
    logic [SSM_HELD_W-1:0]   held_b;

    assign eff_a = (length_a > MAX_LEN) ? MAX_LEN : length_a;
    assign eff_b = (length_b > MAX_LEN) ? MAX_LEN : length_b;

    // Tail of length k matches when cell i holds pattern byte k-1-i for all i < k.
    always_comb
    begin
        for (int k = 1; k <= MAX_STOP_LEN; k++)
        begin
            tail_a[k] = 1'b1;
            tail_b[k] = 1'b1;
            for (int i = 0; i < k; i++)
            begin
                tail_a[k] = tail_a[k] && eq_a[i][k-1-i];
                tail_b[k] = tail_b[k] && eq_b[i][k-1-i];
            end
        end
    end

    // Full match at the effective length; longest proper prefix below it.
    always_comb
    begin
        hit_a  = 1'b0;
        hit_b  = 1'b0;
        held_a = '0;
        held_b = '0;
        for (int k = 1; k <= MAX_STOP_LEN; k++)
        begin
            if (eff_a == SSM_LEN_W'(k))
            begin
                hit_a = tail_a[k];
            end
            if (eff_b == SSM_LEN_W'(k))
            begin
                hit_b = tail_b[k];
            end
        end
        for (int k = 1; k < MAX_STOP_LEN; k++)
        begin
            if ((SSM_LEN_W'(k) < eff_a) && tail_a[k])
            begin
                held_a = SSM_HELD_W'(k);
            end
            if ((SSM_LEN_W'(k) < eff_b) && tail_b[k])
            begin
                held_b = SSM_HELD_W'(k);
            end
        end
    end

    // Longer pattern starts earlier and wins; pattern zero wins a tie.
    always_comb
    begin
        result.match_found   = hit_a || hit_b;
        result.match_pattern = 1'b0;
        result.match_len     = eff_a;
        if (hit_b && (!hit_a || (eff_b > eff_a)))
        begin
            result.match_pattern = 1'b1;
            result.match_len     = eff_b;
        end
        result.held_length = (held_a > held_b) ? held_a : held_b;
    end

endmodule
